// ===== rtl/core/half_float_converter_top_defines.svh =====
// ---------------------------------------------------------------------------
// half_float_converter_top_defines.svh
// Assertion macros for the half/single float converter.
// ---------------------------------------------------------------------------
`ifndef HALF_FLOAT_CONVERTER_TOP_DEFINES_SVH
`define HALF_FLOAT_CONVERTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Plain property, clocked and disabled during reset
`define HFC_ASSERT(lbl, clk_s, rst_n, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (prop)) \
		else $error("hfc assertion failed");
// Same-cycle implication
`define HFC_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hfc implication failed");
// Next-cycle implication
`define HFC_ASSERT_NXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hfc next-cycle check failed");
`else
`define HFC_ASSERT(lbl, clk_s, rst_n, prop)
`define HFC_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons)
`define HFC_ASSERT_NXT(lbl, clk_s, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/hfc_pkg.sv =====
// ---------------------------------------------------------------------------
// hfc_pkg
// Types and constants shared by the half/single float converter.
// ---------------------------------------------------------------------------
package hfc_pkg;

	// Config port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_DIRECTION = 1'b0;
	localparam logic REG_ROUND_TIES_EVEN = 1'b1;

	// Direction codes
	localparam logic DIR_F2H = 1'b0;
	localparam logic DIR_H2F = 1'b1;

	// Item payload width
	localparam int VALUE_W = 32;

	// What stage 3 still has to do with an item
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_FIXED  = 2'd0;	// result already final
	localparam kind_t KIND_ROUND  = 2'd1;	// float to half, round mantissa
	localparam kind_t KIND_DENORM = 2'd2;	// half denormal to float, normalize

	// Single-precision exponent thresholds (biased)
	localparam logic [7:0] F_EXP_OVF  = 8'd143;	// 0x47800000 and up: inf/nan/overflow
	localparam logic [7:0] F_EXP_DEN  = 8'd112;	// below 0x38800000: denormal half
	localparam logic [7:0] F_EXP_ZERO = 8'd102;	// below 0x33000000: signed zero
	localparam logic [7:0] F_EXP_MAX  = 8'hff;
	localparam logic [7:0] DEN_SHIFT_BASE = 8'd113;

	// Half fields
	localparam logic [4:0]  H_EXP_MAX = 5'h1f;
	localparam logic [14:0] H_INF_MAG = 15'h7c00;
	localparam logic [9:0]  H_NAN_MIN = 10'd1;

	// Rounding at 13 guard bits
	localparam logic [13:0] RND_TIE  = 14'h1000;
	localparam logic [24:0] RND_HALF = 25'h1000;

	// Half to float exponent rebias (0x1c000 on the packed half)
	localparam logic [17:0] H2F_REBIAS = 18'h1c000;

	// Stage 2 -> stage 3 work descriptor
	typedef struct packed {
		kind_t        kind;
		logic         dir;
		logic         rte;
		logic         sign;
		logic [23:0]  mant;		// f2h: shifted mantissa; h2f: denormal mantissa
		logic         sticky;
		logic [14:0]  base;		// f2h: exponent field already at bit 10
		logic [3:0]   lz;		// h2f: leading zeros of denormal mantissa
		logic [31:0]  fixed;	// final value for KIND_FIXED
	} work_t;

endpackage

// ===== rtl/core/hfc_stream_if.sv =====
// ---------------------------------------------------------------------------
// hfc_stream_if
// Valid/ready channels for the converter input and output items.
// ---------------------------------------------------------------------------
interface hfc_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] value_in;

	modport source (output valid, output value_in, input ready);
	modport sink   (input valid, input value_in, output ready);
endinterface

interface hfc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] value_out;

	modport source (output valid, output value_out, input ready);
	modport sink   (input valid, input value_out, output ready);
endinterface

// ===== rtl/core/half_float_converter_top.sv =====
// ---------------------------------------------------------------------------
// half_float_converter_top
// Three-stage pipelined binary32 <-> binary16 bit-pattern converter.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : valid/ready sink, one 32-bit item per handshake. In half to
//            float mode only bits 15..0 are used.
//   out_ch : valid/ready source, one converted item per input item, in
//            order. A half result sits in bits 15..0 with bits 31..16 zero.
//   APB    : register 0 (addr 0) direction, 0 float->half, 1 half->float;
//            register 1 (addr 4) round_ties_even, 0 ties away from zero.
//            Write only while no items are in flight.
// out_ch.valid rises once an item has moved through stage 1 and stage 2
// into stage 3. Throughput is one item per cycle while out_ch.ready is
// high: stage 1 registers the item, stage 2 classifies and aligns
// (denormal shift, leading-zero count), stage 3 rounds or normalizes into
// the output register.
// Each stage advances when it is empty or the next one moves, so when the
// receiver stalls the pipe keeps filling its bubbles and then holds; no
// item is dropped or repeated.
// Reset clears all valid bits and both registers to 0.
// ---------------------------------------------------------------------------
`include "half_float_converter_top_defines.svh"

module half_float_converter_top (
	input  logic                            clk,
	input  logic                            arst_n,
	hfc_in_if.sink                          in_ch,
	hfc_out_if.source                       out_ch,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [hfc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [hfc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [hfc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);

	logic dir_q;
	logic rte_q;

	logic        valid_s1, valid_s2, valid_s3;
	logic [31:0] value_s1;
	logic        dir_s1, rte_s1;
	hfc_pkg::work_t work_s2;
	logic [31:0] value_s3;
	logic        dir_s3;

	logic adv1, adv2, adv3;
	hfc_pkg::work_t work_d;
	logic [31:0] result_d;

	// Config registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= 1'b0;
			rte_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				hfc_pkg::REG_DIRECTION:       dir_q <= pwdata[0];
				hfc_pkg::REG_ROUND_TIES_EVEN: rte_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			hfc_pkg::REG_DIRECTION:       prdata = {31'b0, dir_q};
			hfc_pkg::REG_ROUND_TIES_EVEN: prdata = {31'b0, rte_q};
			default:                      prdata = '0;
		endcase
	end

	// Stage enables: a stage moves when empty or when its successor moves
	assign adv3 = !valid_s3 || out_ch.ready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign in_ch.ready = adv1;

	// Stage 1: capture item and mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_ch.valid) begin
			value_s1 <= in_ch.value_in;
			dir_s1   <= dir_q;
			rte_s1   <= rte_q;
		end
	end

	// Stage 2 logic: classify, denormal align, leading-zero count
	always_comb begin
		logic [7:0]  e8;
		logic [22:0] fman;
		logic [3:0]  sh;
		logic [23:0] full;
		logic [23:0] lost_mask;
		logic [7:0]  ebias;
		logic [9:0]  hman;
		logic [4:0]  hexp;
		logic [17:0] nrm;
		logic [3:0]  lz;

		e8        = value_s1[30:23];
		fman      = value_s1[22:0];
		sh        = 4'(hfc_pkg::DEN_SHIFT_BASE - e8);
		full      = {1'b1, fman};
		lost_mask = (24'd1 << sh) - 24'd1;
		ebias     = e8 - hfc_pkg::F_EXP_DEN;
		hman      = value_s1[9:0];
		hexp      = value_s1[14:10];
		nrm       = {3'b0, value_s1[14:0]} + hfc_pkg::H2F_REBIAS;

		lz = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (hman[i]) begin
				lz = 4'(9 - i);
			end
		end

		work_d        = '0;
		work_d.dir    = dir_s1;
		work_d.rte    = rte_s1;
		work_d.kind   = hfc_pkg::KIND_FIXED;

		if (dir_s1 == hfc_pkg::DIR_F2H) begin
			work_d.sign = value_s1[31];
			if (e8 >= hfc_pkg::F_EXP_OVF) begin
				// Infinity, NaN or overflow
				if (e8 == hfc_pkg::F_EXP_MAX && fman != 23'd0) begin
					work_d.fixed = {16'b0, value_s1[31], hfc_pkg::H_EXP_MAX,
						(fman[22:13] == 10'd0) ? hfc_pkg::H_NAN_MIN : fman[22:13]};
				end else begin
					work_d.fixed = {16'b0, value_s1[31], hfc_pkg::H_INF_MAG};
				end
			end else if (e8 <= hfc_pkg::F_EXP_DEN) begin
				if (e8 < hfc_pkg::F_EXP_ZERO) begin
					work_d.fixed = {16'b0, value_s1[31], 15'b0};
				end else begin
					// Half denormal: align with implicit one, track lost bits
					work_d.kind   = hfc_pkg::KIND_ROUND;
					work_d.mant   = full >> sh;
					work_d.sticky = (full & lost_mask) != 24'd0;
					work_d.base   = 15'd0;
				end
			end else begin
				work_d.kind   = hfc_pkg::KIND_ROUND;
				work_d.mant   = {1'b0, fman};
				work_d.sticky = 1'b0;
				work_d.base   = {ebias[4:0], 10'b0};
			end
		end else begin
			work_d.sign = value_s1[15];
			if (hexp == 5'd0) begin
				if (hman == 10'd0) begin
					work_d.fixed = {value_s1[15], 31'b0};
				end else begin
					work_d.kind = hfc_pkg::KIND_DENORM;
					work_d.mant = {14'b0, hman};
					work_d.lz   = lz;
				end
			end else if (hexp == hfc_pkg::H_EXP_MAX) begin
				work_d.fixed = {value_s1[15], hfc_pkg::F_EXP_MAX, hman, 13'b0};
			end else begin
				work_d.fixed = {value_s1[15], nrm, 13'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			work_s2 <= work_d;
		end
	end

	// Stage 3 logic: round to 10 bits, or normalize a half denormal
	always_comb begin
		logic        inc;
		logic [24:0] sum;
		logic [14:0] mag;
		logic [7:0]  fexp;
		logic [10:0] norm;

		inc  = !work_s2.rte || (work_s2.mant[13:0] != hfc_pkg::RND_TIE) || work_s2.sticky;
		sum  = {1'b0, work_s2.mant} + (inc ? hfc_pkg::RND_HALF : 25'd0);
		mag  = work_s2.base + {3'b0, sum[24:13]};
		fexp = hfc_pkg::F_EXP_DEN - {4'b0, work_s2.lz};
		norm = {work_s2.mant[9:0], 1'b0} << work_s2.lz;

		case (work_s2.kind)
			hfc_pkg::KIND_FIXED:  result_d = work_s2.fixed;
			hfc_pkg::KIND_ROUND:  result_d = {16'b0, work_s2.sign, mag};
			hfc_pkg::KIND_DENORM: result_d = {work_s2.sign, fexp, norm[9:0], 13'b0};
			default:              result_d = work_s2.fixed;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			value_s3 <= result_d;
			dir_s3   <= work_s2.dir;
		end
	end

	assign out_ch.valid     = valid_s3;
	assign out_ch.value_out = value_s3;

	// Checks
	`HFC_ASSERT_NXT(a_accept_fills_s1, clk, arst_n, in_ch.valid && in_ch.ready, valid_s1)
	`HFC_ASSERT_NXT(a_s2_held_on_stall, clk, arst_n, valid_s2 && !adv2, valid_s2 && $stable(work_s2))
	`HFC_ASSERT_IMP(a_half_upper_zero, clk, arst_n, valid_s3 && dir_s3 == hfc_pkg::DIR_F2H, value_s3[31:16] == 16'd0)

endmodule
